// ===== sv/opbf_pkg.sv =====
// shared codes and types for the overflow-policy block fifo
package opbf_pkg;

    // request opcodes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    // overflow policy codes, the unused code behaves as reject
    localparam logic [1:0] POL_REJECT   = 2'd0;
    localparam logic [1:0] POL_DROP_NEW = 2'd1;
    localparam logic [1:0] POL_DROP_OLD = 2'd2;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int POL_W    = 2;
    localparam int TALLY_W  = 32;

    // per-cell control from the fifo controller
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// ===== sv/opbf_in_if.sv =====
// request channel: valid/ready with opcode and block handle
interface opbf_in_if #(
    parameter int HANDLE_BITS = 32
);
    import opbf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        opcode;
    logic [HANDLE_BITS-1:0] block_in;

    modport source (output valid, output opcode, output block_in, input ready);
    modport sink   (input valid, input opcode, input block_in, output ready);
endinterface

// ===== sv/opbf_out_if.sv =====
// result channel: valid/ready with status, data, eviction and levels
interface opbf_out_if #(
    parameter int HANDLE_BITS = 32,
    parameter int CNT_W       = 4
);
    import opbf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [HANDLE_BITS-1:0] block_out;
    logic                   evicted_valid;
    logic [HANDLE_BITS-1:0] evicted_block;
    logic [CNT_W-1:0]       fill_level;
    logic [CNT_W-1:0]       high_water;
    logic [TALLY_W-1:0]     drop_count;

    modport source (output valid, output status, output block_out, output evicted_valid,
                    output evicted_block, output fill_level, output high_water,
                    output drop_count, input ready);
    modport sink   (input valid, input status, input block_out, input evicted_valid,
                    input evicted_block, input fill_level, input high_water,
                    input drop_count, output ready);
endinterface

// ===== sv/overflow_policy_block_fifo_unit.sv =====
// top level of the block-handle fifo with configurable overflow policy
//
// Block-handle fifo of DEPTH entries built as a row of shifting cells: cell 0
// always holds the head, a pop or a drop-oldest shifts every cell one place
// toward the head, and a push loads the cell just past the last valid one.
// Each accepted beat on in_ch (push, pop or peek) yields exactly one result
// beat on out_ch in the next cycle, held in a single output register. One
// request is taken every cycle; the only thing that slows intake is a stalled
// out_ch, since a new beat enters only when the output register is empty or
// is being drained in the same cycle. The overflow policy (0 reject, 1 drop
// newest, 2 drop oldest, 3 as reject) is written through cfg_we/cfg_wdata and
// must only change while the block is idle. Stored handles have no reset; a
// slot is read only while the fill count says it is occupied.
module overflow_policy_block_fifo_unit
    import opbf_pkg::*;
#(
    parameter int DEPTH       = 8,
    parameter int HANDLE_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [POL_W-1:0] cfg_wdata,
    opbf_in_if.sink          in_ch,
    opbf_out_if.source       out_ch
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(DEPTH - 1);

    // control state
    logic [POL_W-1:0]   policy_reg;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [CNT_W-1:0]   peak_reg,     peak_next;
    logic [TALLY_W-1:0] tally_reg,    tally_next;
    logic               out_valid_reg;

    // result register
    logic [STATUS_W-1:0]    status_reg,    status_next;
    logic [HANDLE_BITS-1:0] block_out_reg, block_out_next;
    logic                   ev_valid_reg,  ev_valid_next;
    logic [HANDLE_BITS-1:0] ev_block_reg,  ev_block_next;

    // cell row
    logic [HANDLE_BITS-1:0] cell_data [DEPTH];
    logic [HANDLE_BITS-1:0] head_data;
    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   do_shift;
    logic                   do_store;
    logic [CNT_W-1:0]       store_pos;

    assign head_data = cell_data[0];
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);

    // output register drains or is empty: take the next beat
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // request decode
    always_comb
    begin
        count_next     = count_reg;
        peak_next      = peak_reg;
        tally_next     = tally_reg;
        status_next    = ST_OK;
        block_out_next = '0;
        ev_valid_next  = 1'b0;
        ev_block_next  = '0;
        do_shift       = 1'b0;
        do_store       = 1'b0;

        case (in_ch.opcode)
            OP_PUSH:
            begin
                if (full)
                begin
                    tally_next = tally_reg + 1'b1;
                    case (policy_reg)
                        POL_DROP_NEW:
                        begin
                            // incoming handle goes straight back out
                            ev_valid_next = 1'b1;
                            ev_block_next = in_ch.block_in;
                        end
                        POL_DROP_OLD:
                        begin
                            // head leaves, new handle lands in the tail cell
                            ev_valid_next = 1'b1;
                            ev_block_next = head_data;
                            do_shift      = 1'b1;
                            do_store      = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_REJECT;
                        end
                    endcase
                end
                else
                begin
                    do_store   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                // high-water follows every push that was not refused
                if (status_next == ST_OK && count_next > peak_reg)
                begin
                    peak_next = count_next;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    block_out_next = head_data;
                    do_shift       = 1'b1;
                    count_next     = count_reg - 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    block_out_next = head_data;
                end
            end
            default:
            begin
                // unused opcode: report current levels only
            end
        endcase
    end

    // a full fifo only stores after a shift, so the tail cell is the target
    assign store_pos = full ? LAST_IDX : count_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_ctrl_t             ctrl;
            logic [HANDLE_BITS-1:0] nbr;

            assign ctrl.shift = accept && do_shift;
            assign ctrl.load  = accept && do_store && (store_pos == CNT_W'(gi));

            if (gi == DEPTH - 1)
            begin : g_tail
                // nothing behind the tail; its shifted value is never read
                assign nbr = in_ch.block_in;
            end
            else
            begin : g_body
                assign nbr = cell_data[gi + 1];
            end

            opbf_cell #(
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .nbr_data  (nbr),
                .load_data (in_ch.block_in),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    // control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_REJECT;
            count_reg     <= '0;
            peak_reg      <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg <= count_next;
                peak_reg  <= peak_next;
                tally_reg <= tally_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, captured with the beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            block_out_reg <= block_out_next;
            ev_valid_reg  <= ev_valid_next;
            ev_block_reg  <= ev_block_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.block_out     = block_out_reg;
    assign out_ch.evicted_valid = ev_valid_reg;
    assign out_ch.evicted_block = ev_block_reg;
    assign out_ch.fill_level    = count_reg;
    assign out_ch.high_water    = peak_reg;
    assign out_ch.drop_count    = tally_reg;

    // fill count never runs past the cell row
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count exceeds depth");

    // high-water mark never falls below the current fill
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= count_reg)
        else $error("high-water below fill level");

    // drop counter moves only on a push into a full fifo
    a_tally_only_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && in_ch.opcode == OP_PUSH && full) |=> $stable(tally_reg))
        else $error("drop counter moved without overflow");

    // an eviction is always reported with ok status
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ev_valid_reg |-> status_reg == ST_OK)
        else $error("eviction with non-ok status");

    // every accepted beat leaves a result waiting
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

endmodule

// ===== sv/opbf_cell.sv =====
// one storage cell of the shifting fifo row
module opbf_cell
    import opbf_pkg::*;
#(
    parameter int HANDLE_BITS = 32
) (
    input  logic                   clk,
    input  cell_ctrl_t             ctrl,
    input  logic [HANDLE_BITS-1:0] nbr_data,
    input  logic [HANDLE_BITS-1:0] load_data,
    output logic [HANDLE_BITS-1:0] data
);

    logic [HANDLE_BITS-1:0] data_reg;

    // load wins over shift: the tail cell takes the new handle on drop-oldest
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            data_reg <= load_data;
        end
        else if (ctrl.shift)
        begin
            data_reg <= nbr_data;
        end
    end

    assign data = data_reg;

endmodule
